// ===== src/sss_pkg.sv =====
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types for the sample set statistics block: the input beat and the
// result beat.
// ----------------------------------------------------------------------------
`default_nettype none

package sss_pkg;

    localparam int FIELD_W = 24;
    localparam int COUNT_OUT_W = 10;

    typedef struct packed {
        logic [FIELD_W-1:0] sample;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0]     mean_value;
        logic [FIELD_W-1:0]     std_dev;
        logic [FIELD_W-1:0]     min_value;
        logic [FIELD_W-1:0]     max_value;
        logic [COUNT_OUT_W-1:0] sample_count;
        logic                   single_sample;
        logic                   overflowed;
    } out_item_t;

endpackage

`default_nettype wire

// ===== src/sss_ram.sv =====
// ----------------------------------------------------------------------------
// sss_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/sss_queue.sv =====
// ----------------------------------------------------------------------------
// sss_queue
// Two-entry queue of set descriptors between the front and the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_queue #(
    parameter int W = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    output logic              full,
    input  wire logic         pop,
    output logic      [W-1:0] head_data,
    output logic              empty
);

    logic [W-1:0] entry_reg [2];
    logic         wptr_reg, rptr_reg;
    logic [1:0]   cnt_reg, cnt_next;

    assign full      = cnt_reg[1];
    assign empty     = (cnt_reg == 2'd0);
    assign head_data = entry_reg[rptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_data;
        end
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop) begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/sss_front.sv =====
// ----------------------------------------------------------------------------
// sss_front
// Accepts sample beats, stores kept samples into the current bank and keeps
// the running sum, minimum, maximum and count. On the last beat it pushes a
// set descriptor and switches to the other bank.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_front #(
    parameter int MAX_SAMPLES = 512,
    parameter int SW   = 24,
    parameter int CW   = 10,
    parameter int SUMW = 34,
    parameter int AW2  = 10,
    parameter int DESC_W = 1 + 1 + CW + SW + SW + SUMW
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire sss_pkg::in_item_t s_item,
    output logic                   ram_we,
    output logic [AW2-1:0]         ram_waddr,
    output logic [SW-1:0]          ram_wdata,
    output logic                   q_push,
    output logic [DESC_W-1:0]      q_data,
    input  wire logic              q_full,
    input  wire logic              bank_release
);

    localparam logic [1:0] BANKS = 2'd2;

    logic [CW-1:0]   count_reg, count_upd;
    logic [SUMW-1:0] sum_reg, sum_upd;
    logic [SW-1:0]   min_reg, min_upd;
    logic [SW-1:0]   max_reg, max_upd;
    logic            drop_reg, drop_upd;
    logic            bank_reg;
    logic [1:0]      busy_reg, busy_next;
    logic            accept, keep;
    logic [SW-1:0]   v;

    assign s_ready = (busy_reg != BANKS) && !q_full;
    assign accept  = s_valid && s_ready;
    assign v       = s_item.sample[SW-1:0];
    assign keep    = (count_reg < CW'(MAX_SAMPLES));

    always_comb begin
        count_upd = count_reg;
        sum_upd   = sum_reg;
        min_upd   = min_reg;
        max_upd   = max_reg;
        drop_upd  = drop_reg;
        if (keep) begin
            count_upd = count_reg + CW'(1);
            sum_upd   = sum_reg + SUMW'(v);
            if (v < min_reg) begin
                min_upd = v;
            end
            if (v > max_reg) begin
                max_upd = v;
            end
        end else begin
            drop_upd = 1'b1;
        end
    end

    // Store into this set's bank; bank 1 sits above bank 0.
    assign ram_we    = accept && keep;
    assign ram_waddr = AW2'(count_reg) + (bank_reg ? AW2'(MAX_SAMPLES) : AW2'(0));
    assign ram_wdata = v;

    assign q_push = accept && s_item.last;
    assign q_data = {bank_reg, drop_upd, count_upd, max_upd, min_upd, sum_upd};

    always_comb begin
        busy_next = busy_reg;
        if (q_push && !bank_release) begin
            busy_next = busy_reg + 2'd1;
        end else if (bank_release && !q_push) begin
            busy_next = busy_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
            drop_reg  <= 1'b0;
            bank_reg  <= 1'b0;
            busy_reg  <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            if (accept) begin
                if (s_item.last) begin
                    // Clear for the next set and move to the other bank.
                    count_reg <= '0;
                    sum_reg   <= '0;
                    min_reg   <= '1;
                    max_reg   <= '0;
                    drop_reg  <= 1'b0;
                    bank_reg  <= ~bank_reg;
                end else begin
                    count_reg <= count_upd;
                    sum_reg   <= sum_upd;
                    min_reg   <= min_upd;
                    max_reg   <= max_upd;
                    drop_reg  <= drop_upd;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/sss_div.sv =====
// ----------------------------------------------------------------------------
// sss_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_div #(
    parameter int NW = 60,
    parameter int DW = 13
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic      [NW-1:0] quo
);

    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   quo_reg;
    logic [DW-1:0]   rem_reg, rem_step;
    logic [DW-1:0]   den_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg, done_reg;
    logic [DW:0]     part;
    logic            ge;

    assign part = {rem_reg, quo_reg[NW-1]};
    assign ge   = (part >= {1'b0, den_reg});

    always_comb begin
        if (ge) begin
            rem_step = DW'(part - {1'b0, den_reg});
        end else begin
            rem_step = part[DW-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= rem_step;
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(NW - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/sss_sqrt.sv =====
// ----------------------------------------------------------------------------
// sss_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_sqrt #(
    parameter int IW = 60,
    parameter int RW = (IW + 1) / 2
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [IW-1:0] rad,
    output logic               done,
    output logic      [RW-1:0] root
);

    localparam int PW   = 2 * RW;
    localparam int CNTW = $clog2(RW + 1);

    logic [PW-1:0]   rad_reg;
    logic [RW:0]     rem_reg;
    logic [RW-1:0]   root_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg, done_reg;
    logic [RW+2:0]   part, trial;
    logic            ge;

    assign part  = {rem_reg, rad_reg[PW-1:PW-2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign ge    = (part >= trial);

    assign done = done_reg;
    assign root = root_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= PW'(rad);
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg <= {rad_reg[PW-3:0], 2'b00};
            if (ge) begin
                rem_reg  <= (RW + 1)'(part - trial);
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end else begin
                rem_reg  <= part[RW:0];
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(RW - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/sss_back.sv =====
// ----------------------------------------------------------------------------
// sss_back
// Works one set at a time: divides for the mean, sweeps the set's bank to sum
// squared deviations, divides by count minus one, takes the root and hands the
// result to the output register; a single-sample set skips straight to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_back #(
    parameter int MAX_SAMPLES = 512,
    parameter int SW   = 24,
    parameter int CW   = 10,
    parameter int SUMW = 34,
    parameter int AW2  = 10,
    parameter int DEVW = 58,
    parameter int DESC_W = 1 + 1 + CW + SW + SW + SUMW
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_empty,
    output logic                    q_pop,
    input  wire logic [DESC_W-1:0]  q_data,
    output logic                    ram_re,
    output logic [AW2-1:0]          ram_raddr,
    input  wire logic [SW-1:0]      ram_rdata,
    output logic                    bank_release,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output sss_pkg::out_item_t      m_item
);

    localparam int RW = (DEVW + 1) / 2;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MEAN = 6'b000010,
        ST_PASS = 6'b000100,
        ST_DEV  = 6'b001000,
        ST_ROOT = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t          state_reg, state_next;

    logic            h_bank, h_drop;
    logic [CW-1:0]   h_count;
    logic [SW-1:0]   h_max, h_min;
    logic [SUMW-1:0] h_sum;

    logic            bank_reg, drop_reg;
    logic [CW-1:0]   count_reg;
    logic [SW-1:0]   max_reg, min_reg, mean_reg;
    logic [CW-1:0]   iss_reg;
    logic            rvld_reg, dvld_reg, svld_reg;
    logic [SW-1:0]   diff_reg;
    logic [2*SW-1:0] sq_reg;
    logic [DEVW-1:0] acc_reg;
    logic [sss_pkg::FIELD_W-1:0] sd_reg;
    logic            m_valid_reg;
    sss_pkg::out_item_t m_item_reg;

    logic            div_start, div_done;
    logic [DEVW-1:0] div_num, div_quo;
    logic [CW-1:0]   div_den;
    logic            sq_start, sq_done;
    logic [RW-1:0]   sq_root;
    logic            single, pass_end, out_load;

    assign {h_bank, h_drop, h_count, h_max, h_min, h_sum} = q_data;

    assign single   = (count_reg == CW'(1));
    assign pass_end = (state_reg == ST_PASS) && (iss_reg == count_reg)
                      && !rvld_reg && !dvld_reg && !svld_reg;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    assign q_pop = (state_reg == ST_IDLE) && !q_empty;

    // Mean division starts off the queue head; the deviation division at pass end.
    assign div_start = q_pop || pass_end;
    assign div_num   = (state_reg == ST_IDLE) ? DEVW'(h_sum) : acc_reg;
    assign div_den   = (state_reg == ST_IDLE) ? h_count : (count_reg - CW'(1));

    assign sq_start = (state_reg == ST_DEV) && div_done;

    assign ram_re    = (state_reg == ST_PASS) && (iss_reg != count_reg);
    assign ram_raddr = AW2'(iss_reg) + (bank_reg ? AW2'(MAX_SAMPLES) : AW2'(0));

    // Free the bank once nothing more is read from it.
    assign bank_release = pass_end
                          || ((state_reg == ST_MEAN) && div_done && single);

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    sss_div #(
        .NW (DEVW),
        .DW (CW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    sss_sqrt #(
        .IW (DEVW),
        .RW (RW)
    ) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .rad     (div_quo),
        .done    (sq_done),
        .root    (sq_root)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN: begin
                if (div_done) begin
                    state_next = single ? ST_DONE : ST_PASS;
                end
            end
            ST_PASS: begin
                if (pass_end) begin
                    state_next = ST_DEV;
                end
            end
            ST_DEV: begin
                if (div_done) begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (sq_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            bank_reg  <= h_bank;
            drop_reg  <= h_drop;
            count_reg <= h_count;
            max_reg   <= h_max;
            min_reg   <= h_min;
        end
        if ((state_reg == ST_MEAN) && div_done) begin
            mean_reg <= div_quo[SW-1:0];
            acc_reg  <= '0;
            sd_reg   <= '0;
        end
        if (ram_re) begin
            iss_reg <= iss_reg + CW'(1);
        end else if (state_reg != ST_PASS) begin
            iss_reg <= '0;
        end
        if (rvld_reg) begin
            diff_reg <= (ram_rdata >= mean_reg) ? (ram_rdata - mean_reg)
                                                : (mean_reg - ram_rdata);
        end
        if (dvld_reg) begin
            sq_reg <= (2 * SW)'(diff_reg) * (2 * SW)'(diff_reg);
        end
        if (svld_reg) begin
            acc_reg <= acc_reg + DEVW'(sq_reg);
        end
        if ((state_reg == ST_ROOT) && sq_done) begin
            sd_reg <= sss_pkg::FIELD_W'(sq_root);
        end
        if (out_load) begin
            m_item_reg.mean_value    <= sss_pkg::FIELD_W'(mean_reg);
            m_item_reg.std_dev       <= sd_reg;
            m_item_reg.min_value     <= sss_pkg::FIELD_W'(min_reg);
            m_item_reg.max_value     <= sss_pkg::FIELD_W'(max_reg);
            m_item_reg.sample_count  <= sss_pkg::COUNT_OUT_W'(count_reg);
            m_item_reg.single_sample <= single;
            m_item_reg.overflowed    <= drop_reg;
        end
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rvld_reg    <= 1'b0;
            dvld_reg    <= 1'b0;
            svld_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rvld_reg  <= ram_re;
            dvld_reg  <= rvld_reg;
            svld_reg  <= dvld_reg;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/sample_set_statistics.sv =====
// ----------------------------------------------------------------------------
// sample_set_statistics
// Collects a set of unsigned Q8.16 samples, one per input beat with the
// final one marked by last, and returns one result beat per set: mean,
// sample standard deviation, minimum, maximum, kept count, a single-sample
// flag (standard deviation forced to 0) and an overflow flag for samples
// dropped past MAX_SAMPLES. Samples load at one per cycle while the input
// is not stalled, into one of two RAM banks, so the next set can load while
// the previous one is worked on. After the last beat the back end divides
// for the mean, sweeps the set's bank with one RAM read per cycle, divides
// again and takes the root; W is the deviation sum width (the divider
// makes one quotient bit per cycle and runs twice) and R = ceil(W/2) is
// the width of the one-bit-per-cycle root. A single-sample set skips the
// sweep, the second divide and the root. At the defaults W = 58 and R = 29.
// Input stalls when both banks hold sets that the back end has not finished
// reading.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_set_statistics #(
    parameter int MAX_SAMPLES = 512,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire sss_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output sss_pkg::out_item_t      m_item
);

    localparam int SW = (SAMPLE_BITS < sss_pkg::FIELD_W) ? SAMPLE_BITS
                                                         : sss_pkg::FIELD_W;
    localparam int CW     = $clog2(MAX_SAMPLES + 1);
    localparam int SUMW   = SW + CW;
    localparam int DEVW   = 2 * SW + CW;
    localparam int DEPTH  = 2 * MAX_SAMPLES;
    localparam int AW2    = $clog2(DEPTH);
    localparam int DESC_W = 1 + 1 + CW + SW + SW + SUMW;

    logic              ram_we, ram_re;
    logic [AW2-1:0]    ram_waddr, ram_raddr;
    logic [SW-1:0]     ram_wdata, ram_rdata;
    logic              q_push, q_pop, q_full, q_empty;
    logic [DESC_W-1:0] q_in, q_head;
    logic              bank_release;

    sss_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SW          (SW),
        .CW          (CW),
        .SUMW        (SUMW),
        .AW2         (AW2),
        .DESC_W      (DESC_W)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item       (s_item),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .q_push       (q_push),
        .q_data       (q_in),
        .q_full       (q_full),
        .bank_release (bank_release)
    );

    sss_queue #(
        .W (DESC_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head_data (q_head),
        .empty     (q_empty)
    );

    sss_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sss_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SW          (SW),
        .CW          (CW),
        .SUMW        (SUMW),
        .AW2         (AW2),
        .DEVW        (DEVW),
        .DESC_W      (DESC_W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .q_data       (q_head),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .bank_release (bank_release),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item)
    );

endmodule

`default_nettype wire
